>>> rtl/core/rlpl_pkg.sv
package rlpl_pkg;

	localparam int ROUTE_ENTRIES_DEF = 16;
	localparam int PORT_COUNT_DEF    = 4;

	typedef enum logic [1:0] {
		ACT_WRITE_ROUTE = 2'd0,
		ACT_WRITE_PORT  = 2'd1,
		ACT_LOOKUP      = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PORT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic [31:0] prefix_addr;
		logic [31:0] prefix_mask;
		logic [1:0]  port_id;
		logic [31:0] port_addr;
		logic [31:0] lookup_addr;
	} rlpl_in_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  matched_port;
		logic [31:0] source_addr;
		logic [31:0] matched_mask;
	} rlpl_out_t;

	// one route table word
	typedef struct packed {
		logic        valid;
		logic [1:0]  port;
		logic [31:0] mask;
		logic [31:0] prefix;
	} rlpl_route_t;

	// per-cycle memory strobes
	typedef struct packed {
		logic we;
		logic re;
	} rlpl_mem_ctl_t;

endpackage

>>> rtl/core/rlpl_route_mem.sv
module rlpl_route_mem #(
	parameter int DEPTH = rlpl_pkg::ROUTE_ENTRIES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  rlpl_pkg::rlpl_mem_ctl_t ctl,
	input  logic [AW-1:0]         waddr,
	input  rlpl_pkg::rlpl_route_t wdata,
	input  logic [AW-1:0]         raddr,
	output rlpl_pkg::rlpl_route_t rdata
);

	rlpl_pkg::rlpl_route_t mem [DEPTH];
	rlpl_pkg::rlpl_route_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

>>> rtl/core/rlpl_port_mem.sv
module rlpl_port_mem #(
	parameter int DEPTH = rlpl_pkg::PORT_COUNT_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rlpl_pkg::rlpl_mem_ctl_t ctl,
	input  logic [AW-1:0]           waddr,
	input  logic [31:0]             wdata,
	input  logic [AW-1:0]           raddr,
	output logic [31:0]             rdata
);

	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// written flags, an unwritten port reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ctl.re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : 32'd0;

endmodule

>>> rtl/core/rlpl_ctrl.sv
module rlpl_ctrl #(
	parameter int ROUTE_ENTRIES = rlpl_pkg::ROUTE_ENTRIES_DEF,
	parameter int PORT_COUNT    = rlpl_pkg::PORT_COUNT_DEF,
	parameter int RIDX_W        = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
	parameter int PIDX_W        = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  rlpl_pkg::rlpl_in_t      req,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output rlpl_pkg::rlpl_out_t     rsp,
	output rlpl_pkg::rlpl_mem_ctl_t rt_ctl,
	output logic [RIDX_W-1:0]       rt_waddr,
	output rlpl_pkg::rlpl_route_t   rt_wdata,
	output logic [RIDX_W-1:0]       rt_raddr,
	input  rlpl_pkg::rlpl_route_t   rt_rdata,
	output rlpl_pkg::rlpl_mem_ctl_t pt_ctl,
	output logic [PIDX_W-1:0]       pt_waddr,
	output logic [31:0]             pt_wdata,
	output logic [PIDX_W-1:0]       pt_raddr,
	input  logic [31:0]             pt_rdata
);

	localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

	rlpl_pkg::state_t    state_q, state_d;
	logic [CNT_W-1:0]    idx_q;
	logic [31:0]         addr_q;
	logic                found_q;
	logic [31:0]         best_mask_q;
	logic [1:0]          best_port_q;
	rlpl_pkg::rlpl_out_t out_q;
	logic                out_valid_q;

	logic                accept;
	logic                out_load;
	logic                match;
	logic [31:0]         entry32;
	logic [31:0]         wport32;
	logic [31:0]         bport32;
	logic                route_ok;
	logic                wport_ok;
	logic                bport_ok;
	rlpl_pkg::rlpl_out_t res;

	assign entry32  = 32'(req.entry_index);
	assign wport32  = 32'(req.port_id);
	assign bport32  = 32'(best_port_q);
	assign route_ok = entry32 < 32'(ROUTE_ENTRIES);
	assign wport_ok = wport32 < 32'(PORT_COUNT);
	assign bport_ok = bport32 < 32'(PORT_COUNT);

	// entry from the memory against the address being looked up
	assign match = rt_rdata.valid
		&& (((rt_rdata.prefix ^ addr_q) & rt_rdata.mask) == 32'd0)
		&& (rt_rdata.mask >= best_mask_q);

	always_comb begin
		res.hit          = found_q;
		res.matched_port = found_q ? best_port_q : 2'd0;
		res.matched_mask = found_q ? best_mask_q : 32'd0;
		res.source_addr  = (found_q && bport_ok) ? pt_rdata : 32'd0;
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		accept    = 1'b0;
		out_load  = 1'b0;
		rt_ctl    = '0;
		rt_waddr  = '0;
		rt_wdata  = '0;
		rt_raddr  = '0;
		pt_ctl    = '0;
		pt_waddr  = '0;
		pt_wdata  = '0;
		pt_raddr  = '0;
		case (state_q)
			rlpl_pkg::ST_CLEAR: begin
				rt_ctl.we = 1'b1;
				rt_waddr  = idx_q[RIDX_W-1:0];
				if (idx_q == CNT_W'(ROUTE_ENTRIES - 1)) begin
					state_d = rlpl_pkg::ST_IDLE;
				end
			end
			rlpl_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					accept  = 1'b1;
					state_d = rlpl_pkg::ST_FIN;
					case (req.action)
						rlpl_pkg::ACT_WRITE_ROUTE: begin
							rt_ctl.we       = route_ok;
							rt_waddr        = entry32[RIDX_W-1:0];
							rt_wdata.valid  = req.entry_valid;
							rt_wdata.port   = req.port_id;
							rt_wdata.mask   = req.prefix_mask;
							rt_wdata.prefix = req.prefix_addr;
						end
						rlpl_pkg::ACT_WRITE_PORT: begin
							pt_ctl.we = wport_ok;
							pt_waddr  = wport32[PIDX_W-1:0];
							pt_wdata  = req.port_addr;
						end
						rlpl_pkg::ACT_LOOKUP: begin
							rt_ctl.re = 1'b1;
							state_d   = rlpl_pkg::ST_SCAN;
						end
						default: begin
							state_d = rlpl_pkg::ST_FIN;
						end
					endcase
				end
			end
			rlpl_pkg::ST_SCAN: begin
				if (idx_q != CNT_W'(ROUTE_ENTRIES)) begin
					rt_ctl.re = 1'b1;
					rt_raddr  = idx_q[RIDX_W-1:0];
				end else begin
					state_d = rlpl_pkg::ST_PORT;
				end
			end
			rlpl_pkg::ST_PORT: begin
				pt_ctl.re = 1'b1;
				pt_raddr  = bport32[PIDX_W-1:0];
				state_d   = rlpl_pkg::ST_FIN;
			end
			rlpl_pkg::ST_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_d  = rlpl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rlpl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlpl_pkg::ST_CLEAR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rlpl_pkg::ST_CLEAR) begin
				idx_q <= idx_q + CNT_W'(1);
			end else if (accept) begin
				idx_q <= CNT_W'(1);
			end else if (state_q == rlpl_pkg::ST_SCAN && idx_q != CNT_W'(ROUTE_ENTRIES)) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q      <= req.lookup_addr;
			found_q     <= 1'b0;
			best_mask_q <= 32'd0;
			best_port_q <= 2'd0;
		end else if (state_q == rlpl_pkg::ST_SCAN && match) begin
			found_q     <= 1'b1;
			best_mask_q <= rt_rdata.mask;
			best_port_q <= rt_rdata.port;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_lookup_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.action == rlpl_pkg::ACT_LOOKUP |=> state_q == rlpl_pkg::ST_SCAN)
		else $error("lookup did not start a scan");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rlpl_pkg::ST_SCAN |-> idx_q != '0 && idx_q <= CNT_W'(ROUTE_ENTRIES))
		else $error("scan index out of range");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rlpl_pkg::ST_SCAN && idx_q == CNT_W'(ROUTE_ENTRIES)
		|=> state_q == rlpl_pkg::ST_PORT)
		else $error("scan did not end after last entry");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.hit |-> out_q.matched_port == 2'd0
		&& out_q.matched_mask == 32'd0 && out_q.source_addr == 32'd0)
		else $error("miss item carries nonzero fields");

endmodule

>>> rtl/core/route_longest_prefix_lookup_unit.sv
// channel  dir  handshake              payload
// req      in   req_valid / req_ready  rlpl_pkg::rlpl_in_t  (action, route / port / lookup)
// rsp      out  rsp_valid / rsp_ready  rlpl_pkg::rlpl_out_t (hit, port, source, mask)
//
// one item at a time; a write goes from accept to the FIN state, which loads its result
// into the output register once that register is free or rsp_ready is high
// a lookup goes from accept through the SCAN and PORT states to FIN and the output register:
// one route memory read per entry, then one read of the port address memory
// after reset a clearing pass over every route entry zeroes the route valid bits,
// req_ready stays low meanwhile
// the output register lets the next item in while a result waits on rsp_ready
module route_longest_prefix_lookup_unit #(
	parameter int ROUTE_ENTRIES = rlpl_pkg::ROUTE_ENTRIES_DEF,
	parameter int PORT_COUNT    = rlpl_pkg::PORT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  rlpl_pkg::rlpl_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rlpl_pkg::rlpl_out_t rsp
);

	localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

	// route table port
	rlpl_pkg::rlpl_mem_ctl_t rt_ctl;
	logic [RIDX_W-1:0]       rt_waddr;
	rlpl_pkg::rlpl_route_t   rt_wdata;
	logic [RIDX_W-1:0]       rt_raddr;
	rlpl_pkg::rlpl_route_t   rt_rdata;

	// port address table port
	rlpl_pkg::rlpl_mem_ctl_t pt_ctl;
	logic [PIDX_W-1:0]       pt_waddr;
	logic [31:0]             pt_wdata;
	logic [PIDX_W-1:0]       pt_raddr;
	logic [31:0]             pt_rdata;

	// sequencer: clearing pass, writes, linear scan with best-mask tracking
	rlpl_ctrl #(
		.ROUTE_ENTRIES (ROUTE_ENTRIES),
		.PORT_COUNT    (PORT_COUNT),
		.RIDX_W        (RIDX_W),
		.PIDX_W        (PIDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.rt_ctl    (rt_ctl),
		.rt_waddr  (rt_waddr),
		.rt_wdata  (rt_wdata),
		.rt_raddr  (rt_raddr),
		.rt_rdata  (rt_rdata),
		.pt_ctl    (pt_ctl),
		.pt_waddr  (pt_waddr),
		.pt_wdata  (pt_wdata),
		.pt_raddr  (pt_raddr),
		.pt_rdata  (pt_rdata)
	);

	// prefix, mask, port and valid of every route in one word
	rlpl_route_mem #(
		.DEPTH (ROUTE_ENTRIES),
		.AW    (RIDX_W)
	) u_route_mem (
		.clk   (clk),
		.ctl   (rt_ctl),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.raddr (rt_raddr),
		.rdata (rt_rdata)
	);

	// own address per port, unwritten ports read as zero
	rlpl_port_mem #(
		.DEPTH (PORT_COUNT),
		.AW    (PIDX_W)
	) u_port_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pt_ctl),
		.waddr  (pt_waddr),
		.wdata  (pt_wdata),
		.raddr  (pt_raddr),
		.rdata  (pt_rdata)
	);

endmodule
